@@ hw/rtl/tlc_pkg.sv @@
`default_nettype none

package tlc_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_POP    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_REWIND = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [2:0] KIND_EMPTY = 3'd5;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic signed [31:0] gain;
    logic [30:0]        micros;
    logic [1:0]         axis;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{
    kind:    KIND_EMPTY,
    x:       32'sd0,
    y:       32'sd0,
    heading: 32'sd0,
    gain:    32'sd0,
    micros:  31'd0,
    axis:    2'd0
  };

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       popped;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/tlc_mem.sv @@
`default_nettype none

module tlc_mem #(
  parameter int MAX_ENTRIES = tlc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]  waddr,
  input  wire tlc_pkg::entry_t                 wdata,
  input  wire logic                            re,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]  raddr,
  output tlc_pkg::entry_t                      rdata
);

  tlc_pkg::entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tlc_ctrl.sv @@
`default_nettype none

module tlc_ctrl #(
  parameter int MAX_ENTRIES = tlc_pkg::MAX_ENTRIES_DEF,
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      mode,
  input  wire logic [4:0]      position,
  input  wire tlc_pkg::entry_t item,
  input  wire logic            room,
  output tlc_pkg::res_t        res,
  output logic [CW-1:0]        cursor,
  output logic [CW-1:0]        count,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output tlc_pkg::entry_t      mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  wire tlc_pkg::entry_t mem_rdata
);

  localparam int WW = ((CW > 5) ? CW : 5) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]      state;
  logic [2:0]      cur_mode;
  logic [4:0]      cur_pos;
  tlc_pkg::entry_t cur_item;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   cursor_q;
  logic [CW-1:0]   idx;
  logic            pend;
  logic [AW-1:0]   pend_idx;
  logic [1:0]      res_status;
  logic            res_popped;

  logic [WW-1:0] pos_w, cnt_w, cur_w, idx_w;
  logic          full, is_app, bad_pos, can_pop, shift_more;

  always_comb begin
    pos_w      = WW'(cur_pos);
    cnt_w      = WW'(count_q);
    cur_w      = WW'(cursor_q);
    idx_w      = WW'(idx);
    full       = cnt_w >= WW'(MAX_ENTRIES);
    // insert right after the last entry behaves as an append
    is_app     = (cur_mode == tlc_pkg::MODE_APPEND) ||
                 (cur_mode == tlc_pkg::MODE_INSERT && cnt_w != '0 &&
                  pos_w + WW'(1) == cnt_w);
    bad_pos    = (cur_mode == tlc_pkg::MODE_INSERT) && (pos_w >= cnt_w);
    can_pop    = cur_w < cnt_w;
    shift_more = idx_w > pos_w + WW'(1);
  end

  // Shift runs top down: read idx-1 while writing the entry read in the previous
  // cycle one slot higher, so a read never hits a pending write address.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(count_q);
    mem_wdata = cur_item;
    mem_re    = 1'b0;
    mem_raddr = AW'(cursor_q);
    if (state == S_EXEC) begin
      if ((cur_mode == tlc_pkg::MODE_APPEND || cur_mode == tlc_pkg::MODE_INSERT) &&
          is_app && !full) begin
        mem_we = 1'b1;
      end
      if (cur_mode == tlc_pkg::MODE_POP && can_pop) begin
        mem_re = 1'b1;
      end
    end else if (state == S_SHIFT) begin
      if (shift_more) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx - CW'(1));
      end
      if (pend) begin
        mem_we    = 1'b1;
        mem_waddr = pend_idx;
        mem_wdata = mem_rdata;
      end else if (!shift_more) begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_mode <= mode;
            cur_pos  <= position;
            cur_item <= item;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= tlc_pkg::ST_OK;
          res_popped <= 1'b0;
          state      <= S_DONE;
          case (cur_mode) inside
            tlc_pkg::MODE_APPEND, tlc_pkg::MODE_INSERT: begin
              if (is_app) begin
                if (full) begin
                  res_status <= tlc_pkg::ST_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end else if (bad_pos) begin
                res_status <= tlc_pkg::ST_BADPOS;
              end else if (full) begin
                res_status <= tlc_pkg::ST_FULL;
              end else begin
                idx   <= count_q;
                pend  <= 1'b0;
                state <= S_SHIFT;
              end
            end
            tlc_pkg::MODE_POP: begin
              if (can_pop) begin
                res_popped <= 1'b1;
                cursor_q   <= cursor_q + CW'(1);
              end else begin
                res_status <= tlc_pkg::ST_NONE;
              end
            end
            tlc_pkg::MODE_CLEAR: begin
              count_q  <= '0;
              cursor_q <= '0;
            end
            tlc_pkg::MODE_REWIND: begin
              cursor_q <= '0;
            end
            default: begin
            end
          endcase
        end
        S_SHIFT: begin
          if (shift_more) begin
            idx      <= idx - CW'(1);
            pend     <= 1'b1;
            pend_idx <= AW'(idx);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count_q <= count_q + CW'(1);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign res.valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.popped = res_popped;
  assign cursor     = cursor_q;
  assign count      = count_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_q <= count_q)
    else $error("cursor beyond entry count");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (WW'(mem_waddr) <= cnt_w))
    else $error("write past the end of the list");

  a_shift_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> !full)
    else $error("shift started on a full list");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !room) |=> (state == S_DONE))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

@@ hw/rtl/task_list_with_cursor.sv @@
`default_nettype none

// Append, pop, clear, rewind and rejected requests pass the execute and done
// states to out_valid; an insert inside the list also shifts each entry above
// the position up one slot (count - position - 1 entries, one move per cycle).
// The sequencer takes no new request until its result is registered and owns
// the single memory write port, so a shift holds off the next request.
// Reset (rst, synchronous): list empty, cursor zero; entry memory not cleared.
module task_list_with_cursor #(
  parameter int MAX_ENTRIES = tlc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         mode,
  input  wire logic [4:0]         position,
  input  wire logic [2:0]         entry_kind,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] heading,
  input  wire logic signed [31:0] loop_gain,
  input  wire logic [30:0]        wait_micros,
  input  wire logic [1:0]         calib_axis,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_heading,
  output logic signed [31:0]      out_gain,
  output logic [30:0]             out_micros,
  output logic [1:0]              out_axis,
  output logic [5:0]              read_cursor,
  output logic [5:0]              entry_count,
  output logic                    all_done
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);

  tlc_pkg::entry_t item;
  tlc_pkg::entry_t mem_wdata, mem_rdata, res_entry;
  tlc_pkg::res_t   res;
  logic [CW-1:0]   cursor, count;
  logic            mem_we, mem_re, room;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  assign item = '{
    kind:    entry_kind,
    x:       target_x,
    y:       target_y,
    heading: heading,
    gain:    loop_gain,
    micros:  wait_micros,
    axis:    calib_axis
  };

  assign room = !out_valid || out_ready;

  tlc_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .position  (position),
    .item      (item),
    .room      (room),
    .res       (res),
    .cursor    (cursor),
    .count     (count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tlc_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_entry = res.popped ? mem_rdata : tlc_pkg::ENTRY_EMPTY;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && room) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && room) begin
      status      <= res.status;
      out_kind    <= res_entry.kind;
      out_x       <= res_entry.x;
      out_y       <= res_entry.y;
      out_heading <= res_entry.heading;
      out_gain    <= res_entry.gain;
      out_micros  <= res_entry.micros;
      out_axis    <= res_entry.axis;
      read_cursor <= 6'(cursor);
      entry_count <= 6'(count);
      all_done    <= (cursor == count);
    end
  end

endmodule

`default_nettype wire
